@@ design/kcnt_pkg.sv @@
// Shared constants and types for the k-mer count table.
package kcnt_pkg;

   localparam int TABLE_DEPTH    = 4096;
   localparam int MAX_KMER_BYTES = 8;
   localparam int SLOT_W         = $clog2(TABLE_DEPTH);
   localparam int USED_W         = SLOT_W + 1;
   localparam int KEY_W          = 8 * MAX_KMER_BYTES;
   localparam int CNT_W          = 32;
   localparam int LEN_W          = 4;
   localparam int IDX_W          = 12;

   localparam logic [7:0] NEWLINE_BYTE   = 8'd10;
   localparam logic [1:0] SEQ_LINE_PHASE = 2'd1;

   localparam logic CMD_FEED = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic KIND_UPDATE  = 1'b0;
   localparam logic KIND_READOUT = 1'b1;

   localparam logic REG_KMER_LEN   = 1'b0;
   localparam logic REG_FASTQ_MODE = 1'b1;

   typedef enum logic {
      OP_LOOKUP  = 1'b0,
      OP_READOUT = 1'b1
   } op_type;

   // work entry passed from the front part to the back part
   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [IDX_W-1:0]  idx;
   } work_type;

endpackage

@@ design/kcnt_queue.sv @@
// Two-entry queue between the front and back parts.
module kcnt_queue
   import kcnt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output work_type pop_data
);

   work_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/kcnt_front.sv @@
// Front part: configuration registers, line tracking and k-mer windowing.
module kcnt_front
   import kcnt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   input  logic        in_valid,
   input  logic        in_cmd,
   input  logic [7:0]  in_byte,
   input  logic [IDX_W-1:0] in_idx,
   output logic        in_ready,
   output logic        push,
   output work_type    push_data,
   input  logic        q_full
);

   logic [LEN_W-1:0] kmer_len_ff, kmer_len_in;
   logic             fastq_ff, fastq_in;
   logic [KEY_W-1:0] window_ff, window_in;
   logic [3:0]       fill_ff, fill_in;
   logic [1:0]       phase_ff, phase_in;
   logic             accept, wr_en;
   logic [3:0]       eff_k;
   logic [KEY_W-1:0] mask;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign wr_en    = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         REG_KMER_LEN:   csr_prdata = {28'd0, kmer_len_ff};
         REG_FASTQ_MODE: csr_prdata = {31'd0, fastq_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      kmer_len_in = kmer_len_ff;
      fastq_in    = fastq_ff;
      if (wr_en) begin
         if (csr_paddr[2] == REG_KMER_LEN) begin
            kmer_len_in = csr_pwdata[LEN_W-1:0];
         end else begin
            fastq_in = csr_pwdata[0];
         end
      end

      if (kmer_len_ff == 4'd0) begin
         eff_k = 4'd1;
      end else if (kmer_len_ff > 4'(MAX_KMER_BYTES)) begin
         eff_k = 4'(MAX_KMER_BYTES);
      end else begin
         eff_k = kmer_len_ff;
      end
      mask = {KEY_W{1'b1}} >> (7'(MAX_KMER_BYTES - 1) * 7'd8 - {eff_k - 4'd1, 3'b000});

      window_in = window_ff;
      fill_in   = fill_ff;
      phase_in  = phase_ff;
      push      = 1'b0;
      push_data.op  = OP_LOOKUP;
      push_data.key = '0;
      push_data.idx = in_idx;

      if (accept) begin
         if (in_cmd == CMD_READ) begin
            push         = 1'b1;
            push_data.op = OP_READOUT;
         end else if (in_byte == NEWLINE_BYTE) begin
            phase_in = phase_ff + 2'd1;
         end else if (!fastq_ff || phase_ff == SEQ_LINE_PHASE) begin
            window_in = {window_ff[KEY_W-9:0], in_byte};
            if (fill_ff < 4'(MAX_KMER_BYTES)) begin
               fill_in = fill_ff + 4'd1;
            end
            if (fill_in >= eff_k) begin
               push          = 1'b1;
               push_data.key = window_in & mask;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= 4'd8;
         fastq_ff    <= 1'b0;
         window_ff   <= '0;
         fill_ff     <= 4'd0;
         phase_ff    <= 2'd0;
      end else begin
         kmer_len_ff <= kmer_len_in;
         fastq_ff    <= fastq_in;
         window_ff   <= window_in;
         fill_ff     <= fill_in;
         phase_ff    <= phase_in;
      end
   end

endmodule

@@ design/kcnt_back.sv @@
// Back part: table scan, count update, insertion and slot read-out.
module kcnt_back
   import kcnt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  work_type          q_data,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_kind,
   output logic [KEY_W-1:0]  out_key,
   output logic [CNT_W-1:0]  out_count,
   output logic [SLOT_W-1:0] out_slot,
   output logic              out_slot_valid,
   output logic              out_dropped
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_RDOUT
   } state_type;

   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [CNT_W-1:0] cnt_mem [TABLE_DEPTH];

   state_type         state_ff, state_in;
   work_type          cur_ff, cur_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [USED_W-1:0] scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [KEY_W-1:0]  key_q_ff;
   logic [CNT_W-1:0]  cnt_q_ff;

   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [KEY_W-1:0]  okey_ff, okey_in;
   logic [CNT_W-1:0]  ocnt_ff, ocnt_in;
   logic [SLOT_W-1:0] oslot_ff, oslot_in;
   logic              osv_ff, osv_in;
   logic              odrop_ff, odrop_in;

   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic              key_we, cnt_we;
   logic [SLOT_W-1:0] wr_addr;
   logic [CNT_W-1:0]  cnt_wdata;
   logic              out_free, hit;
   logic [CNT_W-1:0]  cnt_inc;

   assign out_valid      = valid_ff;
   assign out_kind       = kind_ff;
   assign out_key        = okey_ff;
   assign out_count      = ocnt_ff;
   assign out_slot       = oslot_ff;
   assign out_slot_valid = osv_ff;
   assign out_dropped    = odrop_ff;

   assign out_free = !valid_ff || out_ready;
   assign hit      = pend_ff && (key_q_ff == cur_ff.key);
   assign cnt_inc  = (cnt_q_ff == {CNT_W{1'b1}}) ? cnt_q_ff : cnt_q_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      used_in     = used_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      rd_ok_in    = rd_ok_ff;
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = scan_ff[SLOT_W-1:0];
      key_we      = 1'b0;
      cnt_we      = 1'b0;
      wr_addr     = pend_idx_ff;
      cnt_wdata   = cnt_inc;

      valid_in = valid_ff && !out_ready;
      kind_in  = kind_ff;
      okey_in  = okey_ff;
      ocnt_in  = ocnt_ff;
      oslot_in = oslot_ff;
      osv_in   = osv_ff;
      odrop_in = odrop_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cur_in  = q_data;
               scan_in = '0;
               pend_in = 1'b0;
               if (q_data.op == OP_READOUT) begin
                  rd_ok_in = ({1'b0, q_data.idx} < used_ff);
                  rd_en    = rd_ok_in;
                  rd_addr  = q_data.idx[SLOT_W-1:0];
                  state_in = B_RDOUT;
               end else begin
                  state_in = B_SCAN;
               end
            end
         end
         B_SCAN: begin
            if (hit) begin
               if (out_free) begin
                  cnt_we   = 1'b1;
                  valid_in = 1'b1;
                  kind_in  = KIND_UPDATE;
                  okey_in  = cur_ff.key;
                  ocnt_in  = cnt_inc;
                  oslot_in = pend_idx_ff;
                  osv_in   = 1'b1;
                  odrop_in = 1'b0;
                  state_in = B_IDLE;
               end
            end else if (scan_ff == used_ff) begin
               // last entry compared without a match: insert or drop
               pend_in = 1'b0;
               if (out_free) begin
                  valid_in = 1'b1;
                  kind_in  = KIND_UPDATE;
                  okey_in  = cur_ff.key;
                  if (used_ff < USED_W'(TABLE_DEPTH)) begin
                     key_we    = 1'b1;
                     cnt_we    = 1'b1;
                     wr_addr   = used_ff[SLOT_W-1:0];
                     cnt_wdata = 32'd1;
                     used_in   = used_ff + 1'b1;
                     ocnt_in   = 32'd1;
                     oslot_in  = used_ff[SLOT_W-1:0];
                     osv_in    = 1'b1;
                     odrop_in  = 1'b0;
                  end else begin
                     ocnt_in  = '0;
                     oslot_in = '0;
                     osv_in   = 1'b0;
                     odrop_in = 1'b1;
                  end
                  state_in = B_IDLE;
               end
            end else begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[SLOT_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end
         end
         B_RDOUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_READOUT;
               okey_in  = rd_ok_ff ? key_q_ff : '0;
               ocnt_in  = rd_ok_ff ? cnt_q_ff : '0;
               oslot_in = cur_ff.idx[SLOT_W-1:0];
               osv_in   = rd_ok_ff;
               odrop_in = 1'b0;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         used_ff  <= '0;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      rd_ok_ff    <= rd_ok_in;
      kind_ff     <= kind_in;
      okey_ff     <= okey_in;
      ocnt_ff     <= ocnt_in;
      oslot_ff    <= oslot_in;
      osv_ff      <= osv_in;
      odrop_ff    <= odrop_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_q_ff <= key_mem[rd_addr];
         cnt_q_ff <= cnt_mem[rd_addr];
      end
      if (key_we) begin
         key_mem[wr_addr] <= cur_ff.key;
      end
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wdata;
      end
   end

endmodule

@@ design/kmer_count_table.sv @@
// K-mer counter: windows a byte stream (newlines skipped, optional FASTQ
// sequence-line filter) and counts each k-mer in a table of TABLE_DEPTH slots
// filled in arrival order; a read command returns one slot. For a feed byte
// that completes a k-mer, the back part scans the occupied slots, so its time
// grows with their number: the lookup scans the key memory one slot per cycle
// through its single read port. Bytes that produce no k-mer are handled in the
// front part alone, and a two-entry queue lets the front keep accepting while
// the back scans.
module kmer_count_table
   import kcnt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,  // data_byte[7:0], slot_index[19:8], zero pad
   input  logic         req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,  // kmer_key[63:0], kmer_count[95:64], slot[107:96],
                                    // slot_valid[108], dropped[109], zero pad
   output logic         rsp_tuser   // kind
);

   logic     push, q_full, q_pop, q_valid;
   work_type push_data, pop_data;
   logic [KEY_W-1:0]  key;
   logic [CNT_W-1:0]  cnt;
   logic [SLOT_W-1:0] slot;
   logic              sv, drop;

   assign csr_pready = 1'b1;

   kcnt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .in_valid    (req_tvalid),
      .in_cmd      (req_tuser),
      .in_byte     (req_tdata[7:0]),
      .in_idx      (req_tdata[19:8]),
      .in_ready    (req_tready),
      .push        (push),
      .push_data   (push_data),
      .q_full      (q_full)
   );

   kcnt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (pop_data)
   );

   kcnt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (pop_data),
      .q_pop          (q_pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_kind       (rsp_tuser),
      .out_key        (key),
      .out_count      (cnt),
      .out_slot       (slot),
      .out_slot_valid (sv),
      .out_dropped    (drop)
   );

   assign rsp_tdata = {2'b00, drop, sv, 12'(slot), cnt, key};

endmodule
